/* sv/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg
// shared constants and types of the sliding pearson correlator
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int WINDOW_LEN  = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int EFF_BITS = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int LOGN     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SW       = EFF_BITS + LOGN + 1;
    localparam int PW       = 2 * EFF_BITS + LOGN + 1;
    localparam int VW       = 2 * EFF_BITS + 2 * LOGN + 1;
    localparam int HW       = (VW + 1) / 2;
    localparam int QW       = 33;
    localparam int RW       = 2 * VW + QW - 1;
    localparam int OW       = QW + 1;
    localparam int FCW      = $clog2(WINDOW_LEN + 1);
    localparam int CNTW     = (LOGN > $clog2(OW)) ? LOGN : $clog2(OW);

    typedef logic signed [EFF_BITS-1:0] smp_t;

    typedef struct packed {
        logic push;
        logic rot;
    } cell_ctrl_t;

    typedef struct packed {
        logic rot;
        logic done;
    } math_stat_t;

endpackage

/* sv/spc_cell.sv */
// ----------------------------------------------------------------------------
// spc_cell
// one window and one template sample, shifted or rotated per enabled cycle
// ----------------------------------------------------------------------------
module spc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spc_pkg::cell_ctrl_t ctrl,
    input  logic               load_y,
    input  spc_pkg::smp_t      load_val,
    input  spc_pkg::smp_t      x_in,
    input  spc_pkg::smp_t      y_in,
    output spc_pkg::smp_t      x_out,
    output spc_pkg::smp_t      y_out
);
    import spc_pkg::*;

    smp_t x_reg;
    smp_t y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
        end
        else if (ctrl.push || ctrl.rot)
        begin
            x_reg <= x_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rot)
        begin
            y_reg <= y_in;
        end
        else if (load_y)
        begin
            y_reg <= load_val;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

/* sv/spc_math.sv */
// ----------------------------------------------------------------------------
// spc_math
// sums over the rotating chain, then variances, wide products, divide, sqrt
// ----------------------------------------------------------------------------
module spc_math (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  spc_pkg::smp_t        x0,
    input  spc_pkg::smp_t        y0,
    output spc_pkg::math_stat_t  stat,
    output logic signed [15:0]   corr,
    output logic                 flag
);
    import spc_pkg::*;

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_ACC  = 4'd1;
    localparam logic [3:0] M_PROD = 4'd2;
    localparam logic [3:0] M_DIFF = 4'd3;
    localparam logic [3:0] M_CHK  = 4'd4;
    localparam logic [3:0] M_WIDE = 4'd5;
    localparam logic [3:0] M_DIV  = 4'd6;
    localparam logic [3:0] M_SQRT = 4'd7;
    localparam logic [3:0] M_FIN  = 4'd8;
    localparam logic [3:0] M_DONE = 4'd9;

    localparam logic signed [VW-1:0] NV = VW'(WINDOW_LEN);

    logic [3:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [PW-1:0] sxx_reg, syy_reg, sxy_reg;
    logic signed [VW-1:0] nxx_reg, nyy_reg, nxy_reg;
    logic signed [VW-1:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [VW-1:0] vx_reg, vy_reg, num_reg;
    logic [2*VW-1:0]      d_reg, m_reg;
    logic [RW-1:0]        rem_reg, dsh_reg;
    logic [QW-1:0]        q_reg;
    logic [OW-1:0]        op_reg, res_reg, one_reg;
    logic signed [15:0]   corr_reg;
    logic                 flag_reg;

    logic signed [2*EFF_BITS-1:0] xx, yy, xy;
    logic signed [2*SW-1:0]       sq_x, sq_y, sq_xy;
    logic [VW-1:0]                mag;
    logic [2*HW-1:0]              a_ext, b_ext;
    logic [HW-1:0]                a_half, b_half;
    logic [2*HW-1:0]              pp;
    logic [2*VW-1:0]              pp_sh;
    logic [OW-1:0]                trial, t_mag;

    assign xx    = x0 * x0;
    assign yy    = y0 * y0;
    assign xy    = x0 * y0;
    assign sq_x  = sx_reg * sx_reg;
    assign sq_y  = sy_reg * sy_reg;
    assign sq_xy = sx_reg * sy_reg;
    assign mag   = num_reg[VW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);

    always_comb
    begin
        if (cnt_reg[2])
        begin
            a_ext = (2*HW)'(mag);
            b_ext = (2*HW)'(mag);
        end
        else
        begin
            a_ext = (2*HW)'($unsigned(vx_reg));
            b_ext = (2*HW)'($unsigned(vy_reg));
        end
        a_half = cnt_reg[0] ? a_ext[2*HW-1:HW] : a_ext[HW-1:0];
        b_half = cnt_reg[1] ? b_ext[2*HW-1:HW] : b_ext[HW-1:0];
        pp     = a_half * b_half;
        case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   pp_sh = (2*VW)'(pp);
            2'b11:   pp_sh = (2*VW)'(pp) << (2 * HW);
            default: pp_sh = (2*VW)'(pp) << HW;
        endcase
        trial = res_reg + one_reg;
        t_mag = (res_reg + OW'(1)) >> 1;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_ACC;
                    cnt_next   = '0;
                end
            end
            M_ACC:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(WINDOW_LEN - 1))
                begin
                    state_next = M_PROD;
                end
            end
            M_PROD: state_next = M_DIFF;
            M_DIFF: state_next = M_CHK;
            M_CHK:
            begin
                cnt_next = '0;
                if (vx_reg <= 0 || vy_reg <= 0)
                begin
                    state_next = M_DONE;
                end
                else
                begin
                    state_next = M_WIDE;
                end
            end
            M_WIDE:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(7))
                begin
                    state_next = M_DIV;
                    cnt_next   = '0;
                end
            end
            M_DIV:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    state_next = M_SQRT;
                    cnt_next   = '0;
                end
            end
            M_SQRT:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(OW / 2 - 1))
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:   state_next = M_DONE;
            M_DONE:  state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                sx_reg  <= '0;
                sy_reg  <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
                sxy_reg <= '0;
            end
            M_ACC:
            begin
                sx_reg  <= sx_reg + SW'(x0);
                sy_reg  <= sy_reg + SW'(y0);
                sxx_reg <= sxx_reg + PW'(xx);
                syy_reg <= syy_reg + PW'(yy);
                sxy_reg <= sxy_reg + PW'(xy);
            end
            M_PROD:
            begin
                nxx_reg <= VW'(sxx_reg) * NV;
                nyy_reg <= VW'(syy_reg) * NV;
                nxy_reg <= VW'(sxy_reg) * NV;
                pxx_reg <= VW'(sq_x);
                pyy_reg <= VW'(sq_y);
                pxy_reg <= VW'(sq_xy);
            end
            M_DIFF:
            begin
                vx_reg  <= nxx_reg - pxx_reg;
                vy_reg  <= nyy_reg - pyy_reg;
                num_reg <= nxy_reg - pxy_reg;
            end
            M_CHK:
            begin
                d_reg    <= '0;
                m_reg    <= '0;
                corr_reg <= '0;
                flag_reg <= (vx_reg <= 0 || vy_reg <= 0);
            end
            M_WIDE:
            begin
                if (cnt_reg[2])
                begin
                    m_reg <= m_reg + pp_sh;
                end
                else
                begin
                    d_reg <= d_reg + pp_sh;
                end
                if (cnt_reg == CNTW'(7))
                begin
                    rem_reg <= {m_reg + pp_sh, 32'd0};
                    dsh_reg <= {d_reg, (QW-1)'(0)};
                    q_reg   <= '0;
                end
            end
            M_DIV:
            begin
                if (dsh_reg <= rem_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    op_reg  <= OW'({q_reg[QW-2:0], dsh_reg <= rem_reg});
                    res_reg <= '0;
                    one_reg <= OW'(1) << (OW - 2);
                end
            end
            M_SQRT:
            begin
                if (op_reg >= trial)
                begin
                    op_reg  <= op_reg - trial;
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
            end
            M_FIN:
            begin
                if (t_mag > OW'(32767))
                begin
                    corr_reg <= num_reg[VW-1] ? -16'sd32767 : 16'sd32767;
                end
                else
                begin
                    corr_reg <= num_reg[VW-1] ? -$signed(t_mag[15:0]) : $signed(t_mag[15:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.rot  = (state_reg == M_ACC);
    assign stat.done = (state_reg == M_DONE);
    assign corr      = corr_reg;
    assign flag      = flag_reg;

endmodule

/* sv/sliding_pearson_correlator.sv */
// ----------------------------------------------------------------------------
// sliding_pearson_correlator
// pearson correlation of a sliding data window against a stored template
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with req_type, sample, template_index.
// a load transaction (req_type 0) writes one template sample; indexes at or
// above the window length are dropped.
// a data transaction (req_type 1) shifts a sample into the window and is
// taken without a stall while the window fills. once the window is full it
// starts a correlation and in_stall stays high until the result is in the
// output register. the cell chain makes a full rotation for the sums, then
// variance math, split wide products, 33 divide steps, 17 square root steps
// and rounding follow; a zero variance window skips products, divide and
// square root.
// the output channel out_valid / out_stall carries correlation (q1.15),
// window_start and zero_variance from a register; a stalled result holds and
// the next transaction is still taken while it waits, but a new result waits
// in the math unit until the register is free.
// reset clears the window to zero, the fill count and the position counter;
// the template is undefined until loaded.
// ----------------------------------------------------------------------------
module sliding_pearson_correlator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [15:0] sample,
    input  logic [5:0]         template_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] correlation,
    output logic [31:0]        window_start,
    output logic               zero_variance
);
    import spc_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_HOLD = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [FCW-1:0] fill_reg;
    logic [31:0]    pos_reg;
    logic [31:0]    ws_reg;
    logic           ov_reg;
    logic signed [15:0] corr_reg;
    logic [31:0]    wso_reg;
    logic           zv_reg;

    logic       acc, data_acc, load_acc, start, out_free, deliver;
    smp_t       new_smp;
    cell_ctrl_t cctrl;
    math_stat_t mstat;
    logic signed [15:0] m_corr;
    logic       m_flag;

    smp_t xo [WINDOW_LEN];
    smp_t yo [WINDOW_LEN];
    smp_t xi [WINDOW_LEN];
    smp_t yi [WINDOW_LEN];
    logic ld [WINDOW_LEN];

    assign acc      = in_valid && !in_stall;
    assign data_acc = acc && req_type;
    assign load_acc = acc && !req_type;
    assign start    = data_acc && (fill_reg >= FCW'(WINDOW_LEN - 1));
    assign new_smp  = $signed(sample[EFF_BITS-1:0]);
    assign out_free = !ov_reg || !out_stall;
    assign deliver  = ((state_reg == T_BUSY && mstat.done) || state_reg == T_HOLD)
                      && out_free;

    assign cctrl.push = data_acc;
    assign cctrl.rot  = mstat.rot;

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (i == WINDOW_LEN - 1)
            begin
                xi[i] = cctrl.push ? new_smp : xo[0];
                yi[i] = yo[0];
            end
            else
            begin
                xi[i] = xo[i+1];
                yi[i] = yo[i+1];
            end
            ld[i] = load_acc && (int'(template_index) == i);
        end
    end

    for (genvar g = 0; g < WINDOW_LEN; g++)
    begin : g_cell
        spc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cctrl),
            .load_y   (ld[g]),
            .load_val (new_smp),
            .x_in     (xi[g]),
            .y_in     (yi[g]),
            .x_out    (xo[g]),
            .y_out    (yo[g])
        );
    end

    spc_math u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .x0    (xo[0]),
        .y0    (yo[0]),
        .stat  (mstat),
        .corr  (m_corr),
        .flag  (m_flag)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    state_next = T_BUSY;
                end
            end
            T_BUSY:
            begin
                if (mstat.done)
                begin
                    state_next = out_free ? T_IDLE : T_HOLD;
                end
            end
            T_HOLD:
            begin
                if (out_free)
                begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            fill_reg  <= '0;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (data_acc)
            begin
                pos_reg <= pos_reg + 32'd1;
                if (fill_reg < FCW'(WINDOW_LEN))
                begin
                    fill_reg <= fill_reg + FCW'(1);
                end
            end
            if (deliver)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ws_reg <= pos_reg - 32'(WINDOW_LEN - 1);
        end
        if (deliver)
        begin
            corr_reg <= m_corr;
            wso_reg  <= ws_reg;
            zv_reg   <= m_flag;
        end
    end

    assign in_stall      = (state_reg != T_IDLE);
    assign out_valid     = ov_reg;
    assign correlation   = corr_reg;
    assign window_start  = wso_reg;
    assign zero_variance = zv_reg;

endmodule

/* sv/spc_checker.sv */
// ----------------------------------------------------------------------------
// spc_checker
// port-level checks of the sliding pearson correlator
// ----------------------------------------------------------------------------
module spc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] correlation,
    input logic               zero_variance
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_zero_var: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_variance |-> correlation == 16'sd0)
        else $error("zero variance with nonzero correlation");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> correlation != -16'sd32768)
        else $error("correlation not saturated");

    a_busy_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a busy period");

endmodule

bind sliding_pearson_correlator spc_checker u_spc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .correlation   (correlation),
    .zero_variance (zero_variance)
);
